FILE: rtl/b32kd_pkg.sv
`timescale 1ns / 1ps
// b32kd_pkg: shared types, constants and the symbol lookup of the base32 key decoder.
// No dependencies.
package b32kd_pkg;

  localparam int unsigned MAX_KEY_BYTES = 64;
  localparam int unsigned KEY_BYTES_W   = 7;
  localparam int unsigned TOTAL_W       = 10;
  localparam int unsigned SYM_BITS      = 5;

  localparam logic [KEY_BYTES_W-1:0] KEY_BYTES_RST = 7'd20;
  localparam logic [7:0]             CHAR_SPACE    = 8'h20;

  typedef enum logic [1:0] {
    CAUSE_FULL    = 2'd0,
    CAUSE_END     = 2'd1,
    CAUSE_INVALID = 2'd2
  } cause_t;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               byte_valid;
    logic [5:0]         byte_index;
    logic               done_res;
    logic [TOTAL_W-1:0] bits_written;
    cause_t             stop_cause;
  } res_t;

  typedef struct packed {
    logic                ok;
    logic [SYM_BITS-1:0] value;
  } sym_t;

  function automatic sym_t symbol_value(input logic [7:0] c);
    sym_t s;
    logic [7:0] d;
    s = '{ok: 1'b0, value: '0};
    d = 8'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      d = c - 8'h41;
      s = '{ok: 1'b1, value: d[SYM_BITS-1:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - 8'h61;
      s = '{ok: 1'b1, value: d[SYM_BITS-1:0]};
    end else if (c inside {[8'h32:8'h37]}) begin
      d = c - 8'h32 + 8'd26;
      s = '{ok: 1'b1, value: d[SYM_BITS-1:0]};
    end
    return s;
  endfunction

endpackage

FILE: rtl/b32kd_core.sv
`timescale 1ns / 1ps
// b32kd_core: key decode state (pending bits, bit counts) and per-character result.
// Depends on b32kd_pkg.
module b32kd_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [7:0]                          char_code,
  input  logic                                end_of_input,
  input  logic [b32kd_pkg::KEY_BYTES_W-1:0]   key_bytes,
  output logic                                push,
  output b32kd_pkg::res_t                     res
);
  import b32kd_pkg::*;

  localparam logic [KEY_BYTES_W-1:0] CAP_MAX =
    (MAX_KEY_BYTES > 127) ? 7'd127 : KEY_BYTES_W'(MAX_KEY_BYTES);

  logic [7:0]         acc_r, acc_nxt;
  logic [2:0]         bib_r, bib_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  logic [KEY_BYTES_W-1:0] cap;
  logic [TOTAL_W:0]       need_bits;
  logic [TOTAL_W:0]       cap_bits;
  logic                   full;
  sym_t                   sym;
  logic [15:0]            win;
  logic [3:0]             nb;
  logic [3:0]             shamt;
  logic [TOTAL_W-1:0]     total_add;
  logic                   finish;
  cause_t                 cause;

  always_comb begin
    cap       = (key_bytes > CAP_MAX) ? CAP_MAX : key_bytes;
    cap_bits  = {1'b0, cap, 3'b000};
    need_bits = {1'b0, total_r} + (TOTAL_W+1)'(SYM_BITS);
    full      = need_bits > cap_bits;
    sym       = symbol_value(char_code);
    shamt     = 4'd11 - {1'b0, bib_r};
    win       = {acc_r, 8'h00} | ({11'd0, sym.value} << shamt);
    nb        = {1'b0, bib_r} + 4'd5;
    total_add = total_r + TOTAL_W'(SYM_BITS);

    finish = 1'b0;
    cause  = CAUSE_FULL;
    if (full) begin
      finish = 1'b1;
    end else if (end_of_input) begin
      finish = 1'b1;
      cause  = CAUSE_END;
    end else if (char_code != CHAR_SPACE && !sym.ok) begin
      finish = 1'b1;
      cause  = CAUSE_INVALID;
    end

    acc_nxt   = acc_r;
    bib_nxt   = bib_r;
    total_nxt = total_r;
    push      = 1'b0;
    res       = '{data_byte: '0, byte_valid: 1'b0, byte_index: '0, done_res: 1'b0,
                  bits_written: total_r, stop_cause: CAUSE_FULL};

    if (accept) begin
      if (finish) begin
        push           = 1'b1;
        res.byte_valid = bib_r != 3'd0;
        res.data_byte  = (bib_r != 3'd0) ? acc_r : 8'h00;
        res.byte_index = (bib_r != 3'd0) ? total_r[8:3] : 6'd0;
        res.done_res   = 1'b1;
        res.stop_cause = cause;
        acc_nxt        = 8'h00;
        bib_nxt        = 3'd0;
        total_nxt      = '0;
      end else if (char_code != CHAR_SPACE) begin
        total_nxt = total_add;
        if (nb[3]) begin
          push             = 1'b1;
          res.byte_valid   = 1'b1;
          res.data_byte    = win[15:8];
          res.byte_index   = total_r[8:3];
          res.bits_written = total_add;
          acc_nxt          = win[7:0];
          bib_nxt          = nb[2:0];
        end else begin
          acc_nxt = win[15:8];
          bib_nxt = nb[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 8'h00;
      bib_r   <= 3'd0;
      total_r <= '0;
    end else begin
      acc_r   <= acc_nxt;
      bib_r   <= bib_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

FILE: rtl/b32kd_outbuf.sv
`timescale 1ns / 1ps
// b32kd_outbuf: result register plus skid entry between decoder and result channel.
// Depends on b32kd_pkg.
module b32kd_outbuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b32kd_pkg::res_t push_res,
  input  logic            out_stall,
  output logic            out_valid,
  output b32kd_pkg::res_t out_res,
  output logic            full
);
  import b32kd_pkg::*;

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  always_comb begin
    pop            = main_valid_r && !out_stall;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_res   = main_r;
  assign full      = skid_valid_r;

endmodule

FILE: rtl/base32_key_decoder.sv
`timescale 1ns / 1ps
// base32_key_decoder: streaming base32 key text decoder, top level.
// Depends on b32kd_pkg, b32kd_core, b32kd_outbuf.
//
// Usage:
//   Input channel: one ASCII character (or an end-of-input marker) per transfer
//   on in_valid/in_stall. Letters in either case and digits 2..7 add 5 bits each;
//   spaces are skipped. Each completed byte gives one result transfer on
//   out_valid/out_stall. A stop (end of input, invalid character, buffer full)
//   gives one result with done_res set, the zero-padded partial byte if any,
//   the bit count and the cause; the decoder then starts a fresh key.
//   Register key_bytes (APB, address 0, reset 20) limits the buffer size.
//   Results are registered: in the result register, or in the skid entry if it is held.
//   Throughput: 1 character per cycle while in_stall is low; decode state updates in one pass.
//   Stalls: a result register and one skid entry hold results; in_stall rises
//   only when both are occupied, and drops the cycle after the receiver takes one.
//   Reset clears the decode state, both output entries and sets key_bytes to 20.
module base32_key_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic        out_byte_valid,
  output logic [5:0]  out_byte_index,
  output logic        out_done_res,
  output logic [9:0]  out_bits_written,
  output logic [1:0]  out_stop_cause,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import b32kd_pkg::*;

  localparam logic ADDR_KEY_BYTES = 1'b0;

  logic [KEY_BYTES_W-1:0] key_bytes_r;
  logic                   accept;
  logic                   push;
  logic                   buf_full;
  res_t                   push_res;
  res_t                   out_res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_KEY_BYTES) ? {25'd0, key_bytes_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r <= KEY_BYTES_RST;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_KEY_BYTES) begin
      key_bytes_r <= pwdata[KEY_BYTES_W-1:0];
    end
  end

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  b32kd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .char_code    (in_char_code),
    .end_of_input (in_end_of_input),
    .key_bytes    (key_bytes_r),
    .push         (push),
    .res          (push_res)
  );

  b32kd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (buf_full)
  );

  assign out_data_byte    = out_res.data_byte;
  assign out_byte_valid   = out_res.byte_valid;
  assign out_byte_index   = out_res.byte_index;
  assign out_done_res     = out_res.done_res;
  assign out_bits_written = out_res.bits_written;
  assign out_stop_cause   = out_res.stop_cause;

  a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid entry occupied while result register empty");

  a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> (out_data_byte == 8'h00 && out_byte_index == 6'd0))
    else $error("result without byte carries nonzero byte fields");

  a_mid_key_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> (out_byte_valid && out_stop_cause == CAUSE_FULL))
    else $error("mid-key result without byte or with stop cause");

endmodule

FILE: sim/tb_base32_key_decoder.sv
`timescale 1ns / 1ps
// tb_base32_key_decoder: self-checking testbench for the base32 key decoder; a directed
// run, then random key text under several key_bytes settings, checked against a local decoder.
// Depends on b32kd_pkg and base32_key_decoder.
module tb_base32_key_decoder;
  import b32kd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [2:0]  ADDR_KEY_BYTES = 3'd0;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
  } char_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_data_byte;
  logic        out_byte_valid;
  logic [5:0]  out_byte_index;
  logic        out_done_res;
  logic [9:0]  out_bits_written;
  logic [1:0]  out_stop_cause;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  char_item_t  char_queue[$];
  res_t        want_results[$];
  bit          calm = 1'b0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;

  // decoder state as seen from outside
  logic [6:0]  kb_model = KEY_BYTES_RST;
  logic [7:0]  acc_bits = 8'h00;
  int unsigned pend_bits = 0;
  int unsigned total_bits = 0;

  base32_key_decoder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_byte   (out_data_byte),
    .out_byte_valid  (out_byte_valid),
    .out_byte_index  (out_byte_index),
    .out_done_res    (out_done_res),
    .out_bits_written(out_bits_written),
    .out_stop_cause  (out_stop_cause),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) flag($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic void close_key(input cause_t cause);
    res_t r;
    r = '0;
    r.byte_valid = (pend_bits != 0);
    r.data_byte = r.byte_valid ? acc_bits : 8'h00;
    r.byte_index = r.byte_valid ? 6'(total_bits / 8) : 6'd0;
    r.done_res = 1'b1;
    r.bits_written = 10'(total_bits);
    r.stop_cause = cause;
    want_results.push_back(r);
    acc_bits = 8'h00;
    pend_bits = 0;
    total_bits = 0;
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic eoi);
    int unsigned cap;
    int unsigned nb;
    int unsigned idx;
    logic [7:0]  d;
    logic        ok;
    logic [15:0] win;
    res_t        r;
    cap = (kb_model > MAX_KEY_BYTES) ? MAX_KEY_BYTES : kb_model;
    ok = 1'b1;
    d = 8'h00;
    if (c >= "A" && c <= "Z") d = c - "A";
    else if (c >= "a" && c <= "z") d = c - "a";
    else if (c >= "2" && c <= "7") d = c - "2" + 8'd26;
    else ok = 1'b0;
    if (total_bits + 5 > cap * 8) begin
      close_key(CAUSE_FULL);
    end else if (eoi) begin
      close_key(CAUSE_END);
    end else if (c == CHAR_SPACE) begin
      return;
    end else if (!ok) begin
      close_key(CAUSE_INVALID);
    end else begin
      win = {acc_bits, 8'h00} | (16'(d[4:0]) << (11 - pend_bits));
      nb = pend_bits + 5;
      idx = total_bits / 8;
      total_bits += 5;
      if (nb >= 8) begin
        r = '0;
        r.data_byte = win[15:8];
        r.byte_valid = 1'b1;
        r.byte_index = 6'(idx);
        r.bits_written = 10'(total_bits);
        r.stop_cause = CAUSE_FULL;
        want_results.push_back(r);
        acc_bits = win[7:0];
        pend_bits = nb - 8;
      end else begin
        acc_bits = win[15:8];
        pend_bits = nb;
      end
    end
  endfunction

  // input side
  always @(posedge clk) begin
    char_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_char(in_char_code, in_end_of_input);
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (char_queue.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else if (char_queue.size() != 0) begin
          nxt = char_queue.pop_front();
          in_valid <= 1'b1;
          in_char_code <= nxt.ch;
          in_end_of_input <= nxt.eoi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_results.size() == 0) begin
          flag($sformatf("unexpected transfer: byte %02h valid %0b done %0b bits %0d",
                         out_data_byte, out_byte_valid, out_done_res, out_bits_written));
        end else begin
          want = want_results.pop_front();
          check_field("data_byte", out_data_byte, want.data_byte);
          check_field("byte_valid", out_byte_valid, want.byte_valid);
          check_field("byte_index", out_byte_index, want.byte_index);
          check_field("done_res", out_done_res, want.done_res);
          check_field("bits_written", out_bits_written, want.bits_written);
          check_field("stop_cause", out_stop_cause, want.stop_cause);
        end
      end
      if (calm) begin
        out_stall <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_char(input logic [7:0] ch, input logic eoi);
    char_item_t it;
    it.ch = ch;
    it.eoi = eoi;
    char_queue.push_back(it);
  endtask

  function automatic logic [7:0] good_char();
    int unsigned v;
    v = $urandom_range(0, 31);
    if (v >= 26) return 8'("2" + v - 26);
    return $urandom_range(0, 1) ? 8'("A" + v) : 8'("a" + v);
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "2" && c <= "7") || c == CHAR_SPACE);
    return c;
  endfunction

  task automatic apb_write(input logic [6:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_KEY_BYTES;
    pwdata <= {25'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    kb_model = v;
  endtask

  task automatic apb_read_check();
    logic [31:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_KEY_BYTES;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    check_field("key_bytes readback", got, {25'd0, kb_model});
  endtask

  // random key text; well-formed keys dominate, spaces are not counted
  task automatic fill_phase(input int unsigned target);
    int unsigned made;
    int unsigned cap_chars;
    int unsigned len;
    int unsigned kind;
    int unsigned k;
    cap_chars = ((kb_model > MAX_KEY_BYTES) ? MAX_KEY_BYTES : kb_model) * 8 / 5;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        len = $urandom_range(1, cap_chars + 2);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 11) == 0) push_char(CHAR_SPACE, 1'b0);
          push_char(good_char(), 1'b0);
        end
        made += len;
        if ($urandom_range(0, 4) != 0) begin
          push_char(8'($urandom_range(0, 255)), 1'b1);
          made++;
        end
      end else if (kind == 7) begin
        push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        made++;
      end else if (kind == 8) begin
        len = $urandom_range(0, 6);
        for (k = 0; k < len; k++) push_char(good_char(), 1'b0);
        push_char(bad_char(), 1'b0);
        made += len + 1;
      end else begin
        push_char(8'($urandom_range(0, 255)), 1'b1);
        made++;
      end
    end
  endtask

  task automatic drain();
    while (char_queue.size() != 0 || in_valid || want_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [6:0] settings[$];
    int unsigned i;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    apb_read_check();

    // directed: symbol range extremes, both cases, flushes, empty key, invalid stops
    push_char("A", 1'b0);
    push_char("Z", 1'b0);
    push_char("a", 1'b0);
    push_char("z", 1'b0);
    push_char("2", 1'b0);
    push_char("7", 1'b0);
    push_char(8'hFF, 1'b1);
    push_char(8'h00, 1'b1);
    push_char("8", 1'b0);
    push_char("B", 1'b0);
    push_char(CHAR_SPACE, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char("m", 1'b0);
    push_char("Y", 1'b0);
    push_char(8'h00, 1'b0);
    push_char("1", 1'b0);
    drain();

    settings = '{7'd1, 7'd0, 7'd2, 7'd64, 7'd7, 7'd127, 7'd100, 7'd3};
    for (i = 0; i < 3; i++) settings.push_back(7'($urandom_range(1, 12)));
    settings.push_back(KEY_BYTES_RST);
    for (i = 0; i < settings.size(); i++) begin
      apb_write(settings[i]);
      apb_read_check();
      if (i == settings.size() - 1) calm = 1'b1;
      fill_phase((settings[i] >= 7'd64) ? 40 : 28);
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/b32kd_pkg.sv
rtl/b32kd_core.sv
rtl/b32kd_outbuf.sv
rtl/base32_key_decoder.sv
sim/tb_base32_key_decoder.sv
